// File: rtl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants for the quaternion orientation integrator.
// ----------------------------------------------------------------------------
package qoi_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQ,
    ST_DIV,
    ST_SQRT,
    ST_SCALE,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MAC,
    OP_AWR,
    OP_SQ,
    OP_DIV,
    OP_SQRT,
    OP_SCALE
  } op_e;

  // one micro-op from the controller to the datapath
  typedef struct packed {
    op_e        op;
    logic [1:0] sel;   // quaternion component
    logic [1:0] vsel;  // vector component
    logic       neg;   // subtract the product
    logic       first; // first step of a pass
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
  } sts_t;

  localparam int unsigned CNT_W = 6;

  localparam logic [CNT_W-1:0] PROD_LAST  = CNT_W'(15);
  localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(62);
  localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(31);
  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(3);

  typedef struct packed {
    logic [1:0] qsel;
    logic [1:0] vsel;
    logic       neg;
  } term_t;

  // Hamilton product q * (0, v): three terms per component
  function automatic term_t term_f(input logic [1:0] comp, input logic [1:0] term);
    term_t t;
    t = '0;
    case ({comp, term})
      4'h0: t = '{qsel: 2'd1, vsel: 2'd0, neg: 1'b1};
      4'h1: t = '{qsel: 2'd2, vsel: 2'd1, neg: 1'b1};
      4'h2: t = '{qsel: 2'd3, vsel: 2'd2, neg: 1'b1};
      4'h4: t = '{qsel: 2'd0, vsel: 2'd0, neg: 1'b0};
      4'h5: t = '{qsel: 2'd2, vsel: 2'd2, neg: 1'b0};
      4'h6: t = '{qsel: 2'd3, vsel: 2'd1, neg: 1'b1};
      4'h8: t = '{qsel: 2'd0, vsel: 2'd1, neg: 1'b0};
      4'h9: t = '{qsel: 2'd3, vsel: 2'd0, neg: 1'b0};
      4'hA: t = '{qsel: 2'd1, vsel: 2'd2, neg: 1'b1};
      4'hC: t = '{qsel: 2'd0, vsel: 2'd2, neg: 1'b0};
      4'hD: t = '{qsel: 2'd1, vsel: 2'd1, neg: 1'b0};
      4'hE: t = '{qsel: 2'd2, vsel: 2'd0, neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/quaternion_orientation_integrate.sv
// ----------------------------------------------------------------------------
// quaternion_orientation_integrate
// Integrates a rotation vector into an orientation quaternion and renormalises.
// ----------------------------------------------------------------------------
// A new beat is taken only once the last result has gone to the result register;
// the divide and square root passes are skipped when |a|^2 is zero. The 63-step
//   divider and the 32-step square root make one bit per cycle on the shared datapath.
// A result waits in its own register while the next beat is being worked on.
// Reset (async, active low): orientation returns to identity, no result held.
module quaternion_orientation_integrate #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);

  qoi_pkg::cmd_t cmd;
  qoi_pkg::sts_t sts;
  logic          load_v;
  logic          load_out;

  // Sequence per beat: 12 multiply-accumulates plus 4 round/add writes form
  // q + p/2, then 4 squares give |a|^2, then 2^62/|a|^2 bit by bit, its root
  // two bits a step, and 4 scaling multiplies back into the orientation.
  qoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .load_v_o    (load_v),
    .load_out_o  (load_out)
  );

  qoi_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .load_v_i   (load_v),
    .load_out_i (load_out),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .sts_o      (sts),
    .quat_w_o   (quat_w_o),
    .quat_x_o   (quat_x_o),
    .quat_y_o   (quat_y_o),
    .quat_z_o   (quat_z_o)
  );

endmodule

// File: rtl/qoi_ctrl.sv
// ----------------------------------------------------------------------------
// qoi_ctrl
// Sequencer: steps the datapath through product, magnitude, divide,
// square root and scale passes, and owns both handshakes.
// ----------------------------------------------------------------------------
module qoi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  qoi_pkg::sts_t sts_i,
  output qoi_pkg::cmd_t cmd_o,
  output logic          load_v_o,
  output logic          load_out_o
);

  qoi_pkg::state_e             state_q, state_d;
  logic [qoi_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  qoi_pkg::term_t              term;

  assign out_free = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      qoi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = qoi_pkg::ST_PROD;
          cnt_d   = '0;
        end
      end
      qoi_pkg::ST_PROD: begin
        if (cnt_q == qoi_pkg::PROD_LAST) begin
          state_d = qoi_pkg::ST_SQ;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      qoi_pkg::ST_SQ: begin
        if (cnt_q == qoi_pkg::SQ_LAST) begin
          state_d = qoi_pkg::ST_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      qoi_pkg::ST_DIV: begin
        if (sts_i.mag_zero && cnt_q == '0) begin
          state_d = qoi_pkg::ST_SCALE;
          cnt_d   = '0;
        end else if (cnt_q == qoi_pkg::DIV_LAST) begin
          state_d = qoi_pkg::ST_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      qoi_pkg::ST_SQRT: begin
        if (cnt_q == qoi_pkg::SQRT_LAST) begin
          state_d = qoi_pkg::ST_SCALE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      qoi_pkg::ST_SCALE: begin
        if (cnt_q == qoi_pkg::SCALE_LAST) begin
          state_d = qoi_pkg::ST_HOLD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      qoi_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = qoi_pkg::ST_IDLE;
        end
      end
      default: state_d = qoi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = qoi_pkg::OP_NONE;
    load_v_o   = 1'b0;
    load_out_o = 1'b0;
    term       = qoi_pkg::term_f(cnt_q[3:2], cnt_q[1:0]);
    unique case (state_q)
      qoi_pkg::ST_IDLE: load_v_o = in_valid_i;
      qoi_pkg::ST_PROD: begin
        if (cnt_q[1:0] == 2'd3) begin
          cmd_o.op  = qoi_pkg::OP_AWR;
          cmd_o.sel = cnt_q[3:2];
        end else begin
          cmd_o.op    = qoi_pkg::OP_MAC;
          cmd_o.sel   = term.qsel;
          cmd_o.vsel  = term.vsel;
          cmd_o.neg   = term.neg;
          cmd_o.first = (cnt_q[1:0] == 2'd0);
        end
      end
      qoi_pkg::ST_SQ: begin
        cmd_o.op    = qoi_pkg::OP_SQ;
        cmd_o.sel   = cnt_q[1:0];
        cmd_o.first = (cnt_q == '0);
      end
      qoi_pkg::ST_DIV: begin
        cmd_o.op    = (sts_i.mag_zero && cnt_q == '0) ? qoi_pkg::OP_NONE : qoi_pkg::OP_DIV;
        cmd_o.first = (cnt_q == '0);
      end
      qoi_pkg::ST_SQRT: begin
        cmd_o.op    = qoi_pkg::OP_SQRT;
        cmd_o.first = (cnt_q == '0);
      end
      qoi_pkg::ST_SCALE: begin
        cmd_o.op  = qoi_pkg::OP_SCALE;
        cmd_o.sel = cnt_q[1:0];
      end
      qoi_pkg::ST_HOLD: load_out_o = out_free;
      default: cmd_o.op = qoi_pkg::OP_NONE;
    endcase
  end

  assign out_valid_d = load_out_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qoi_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != qoi_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/qoi_dpath.sv
// ----------------------------------------------------------------------------
// qoi_dpath
// Datapath: shared multiplier with accumulator, bit-serial divider,
// digit-by-digit square root, orientation and result registers.
// ----------------------------------------------------------------------------
module qoi_dpath #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qoi_pkg::cmd_t      cmd_i,
  input  logic               load_v_i,
  input  logic               load_out_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output qoi_pkg::sts_t      sts_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);

  localparam int ONE_I = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam logic signed [15:0] ONE = 16'(ONE_I);
  localparam int SC_SH = 31 - FRAC_BITS;

  function automatic logic signed [15:0] sat_f(input logic signed [49:0] v);
    if (v > 50'sd32767)       return 16'sh7fff;
    else if (v < -50'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  logic signed [15:0] v_q   [3];
  logic signed [15:0] q_q   [4];
  logic signed [15:0] q_d   [4];
  logic signed [15:0] a_q   [4];
  logic signed [15:0] res_q [4];
  logic signed [33:0] acc_q, acc_d;
  logic [33:0]        rem_q, rem_d;
  logic [63:0]        quot_q, quot_d;
  logic [31:0]        root_q, root_d;

  logic signed [15:0] op_a, v_sel;
  logic signed [32:0] op_b;
  logic signed [48:0] prod;
  logic signed [33:0] pterm, acc_base;
  logic signed [34:0] awr_sum, awr_rnd;
  logic signed [35:0] awr_tot;
  logic signed [49:0] sc_sum, sc_rnd;
  logic [33:0]        div_sh;
  logic               div_ge;
  logic [33:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [35:0]        sq_r2, sq_trial;
  logic               sq_ge;

  assign sts_o.mag_zero = (acc_q == '0);

  always_comb begin
    case (cmd_i.vsel)
      2'd0:    v_sel = v_q[0];
      2'd1:    v_sel = v_q[1];
      default: v_sel = v_q[2];
    endcase
    op_a = (cmd_i.op == qoi_pkg::OP_MAC) ? q_q[cmd_i.sel] : a_q[cmd_i.sel];
    case (cmd_i.op)
      qoi_pkg::OP_MAC:   op_b = 33'(v_sel);
      qoi_pkg::OP_SCALE: op_b = $signed({1'b0, root_q});
      default:           op_b = 33'(a_q[cmd_i.sel]);
    endcase
    prod = op_a * op_b;
  end

  // accumulate, add-and-round, divide, root and scale
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    root_d = root_q;
    q_d    = q_q;

    pterm    = $signed(prod[33:0]);
    acc_base = cmd_i.first ? '0 : acc_q;

    awr_sum = 35'(acc_q) + (35'sd1 <<< FRAC_BITS);
    awr_rnd = awr_sum >>> (FRAC_BITS + 1);
    awr_tot = 36'(awr_rnd) + 36'(q_q[cmd_i.sel]);

    sc_sum = 50'(prod) + (50'sd1 <<< (SC_SH - 1));
    sc_rnd = sc_sum >>> SC_SH;

    // dividend is 2^62: its only set bit enters on the first step
    div_sh = cmd_i.first ? 34'd1 : {rem_q[32:0], 1'b0};
    div_ge = (div_sh >= {1'b0, acc_q[32:0]});

    sq_rem   = cmd_i.first ? '0 : rem_q;
    sq_root  = cmd_i.first ? '0 : root_q;
    sq_r2    = {sq_rem, quot_q[63:62]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_ge    = (sq_r2 >= sq_trial);

    case (cmd_i.op)
      qoi_pkg::OP_MAC: acc_d = acc_base + (cmd_i.neg ? -pterm : pterm);
      qoi_pkg::OP_SQ:  acc_d = acc_base + pterm;
      qoi_pkg::OP_DIV: begin
        rem_d  = div_ge ? (div_sh - {1'b0, acc_q[32:0]}) : div_sh;
        quot_d = {(cmd_i.first ? 63'd0 : quot_q[62:0]), div_ge};
      end
      qoi_pkg::OP_SQRT: begin
        rem_d  = sq_ge ? 34'(sq_r2 - sq_trial) : sq_r2[33:0];
        root_d = {sq_root[30:0], sq_ge};
        quot_d = {quot_q[61:0], 2'b00};
      end
      qoi_pkg::OP_SCALE: begin
        if (sts_o.mag_zero) begin
          q_d[cmd_i.sel] = (cmd_i.sel == 2'd0) ? ONE : 16'sd0;
        end else begin
          q_d[cmd_i.sel] = sat_f(sc_rnd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= ONE;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_v_i) begin
      v_q[0] <= vec_x_i;
      v_q[1] <= vec_y_i;
      v_q[2] <= vec_z_i;
    end
    if (cmd_i.op == qoi_pkg::OP_AWR) begin
      a_q[cmd_i.sel] <= sat_f(50'(awr_tot));
    end
    if (load_out_i) begin
      res_q <= q_q;
    end
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    root_q <= root_d;
  end

  assign quat_w_o = res_q[0];
  assign quat_x_o = res_q[1];
  assign quat_y_o = res_q[2];
  assign quat_z_o = res_q[3];

endmodule

// File: rtl/qoi_checker.sv
// ----------------------------------------------------------------------------
// qoi_checker
// Port-level checks for the quaternion orientation integrator.
// ----------------------------------------------------------------------------
module qoi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] quat_w_o,
  input logic [15:0] quat_x_o,
  input logic [15:0] quat_y_o,
  input logic [15:0] quat_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(quat_w_o) && $stable(quat_x_o)
      && $stable(quat_y_o) && $stable(quat_z_o))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the beat was processed");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("new result shown while engine still busy");

endmodule

bind quaternion_orientation_integrate qoi_checker u_qoi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .quat_w_o    (quat_w_o),
  .quat_x_o    (quat_x_o),
  .quat_y_o    (quat_y_o),
  .quat_z_o    (quat_z_o)
);

// File: bench/quaternion_orientation_integrate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_orientation_integrate_tb
// Drives rotation vectors into the orientation integrator and checks every
// updated quaternion against a bit-exact fixed point predictor, with random
// idle cycles on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrate_tb;

  localparam int unsigned FRAC_BITS   = 14;
  localparam int          N_DIRECTED  = 22;
  localparam int          N_RANDOM    = 1400;
  localparam int          QUIET_FIRST = 300;   // no idling on either side
  localparam int          QUIET_LAST  = 500;   //   for items in this window
  localparam longint      CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 200;   // extra wait after the last result is checked

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  // Holds the running orientation and the queue of quaternions still owed.
  class attitude_scoreboard;
    longint ow, ox, oy, oz;
    quat_t  pending[$];
    int     errors;
    int     n_checked;

    function new();
      ow = sat16(longint'(1) << FRAC_BITS);
      ox = 0;
      oy = 0;
      oz = 0;
      errors = 0;
      n_checked = 0;
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // round half up: floor((v + 2^(s-1)) / 2^s)
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (longint'(1) << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Advance the orientation by one rotation vector; queue the new quaternion.
    function void note_vector(logic signed [15:0] vx_i, logic signed [15:0] vy_i,
                              logic signed [15:0] vz_i);
      longint vx, vy, vz;
      longint p[4], a[4], q[4], r[4];
      longint unsigned mag, inv;
      quat_t  e;
      vx = vx_i;
      vy = vy_i;
      vz = vz_i;
      q[0] = ow; q[1] = ox; q[2] = oy; q[3] = oz;
      p[0] = -ox * vx - oy * vy - oz * vz;
      p[1] =  ow * vx + oy * vz - oz * vy;
      p[2] =  ow * vy + oz * vx - ox * vz;
      p[3] =  ow * vz + ox * vy - oy * vx;
      mag = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = sat16(q[i] + round_shift(p[i], FRAC_BITS + 1));
        mag += longint'(a[i] * a[i]);
      end
      if (mag == 0) begin
        r[0] = sat16(longint'(1) << FRAC_BITS);
        r[1] = 0; r[2] = 0; r[3] = 0;
      end else begin
        inv = int_sqrt((longint'(1) << 62) / mag);
        for (int i = 0; i < 4; i++)
          r[i] = sat16(round_shift(a[i] * longint'(inv), 31 - FRAC_BITS));
      end
      ow = r[0]; ox = r[1]; oy = r[2]; oz = r[3];
      e.w = r[0][15:0];
      e.x = r[1][15:0];
      e.y = r[2][15:0];
      e.z = r[3][15:0];
      pending.push_back(e);
    endfunction

    task check_quat(quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result w=%0d x=%0d y=%0d z=%0d",
                         got.w, got.x, got.y, got.z));
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.w !== e.w) report($sformatf("#%0d w got %0d exp %0d", n_checked, got.w, e.w));
      if (got.x !== e.x) report($sformatf("#%0d x got %0d exp %0d", n_checked, got.x, e.x));
      if (got.y !== e.y) report($sformatf("#%0d y got %0d exp %0d", n_checked, got.y, e.y));
      if (got.z !== e.z) report($sformatf("#%0d z got %0d exp %0d", n_checked, got.z, e.z));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] vec_x_i, vec_y_i, vec_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  attitude_scoreboard sb;
  longint n_cycles;
  int     n_sent;
  bit     quiet;        // long stretch with no idling on either side

  quaternion_orientation_integrate #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .quat_w_o   (quat_w_o),
    .quat_x_o   (quat_x_o),
    .quat_y_o   (quat_y_o),
    .quat_z_o   (quat_z_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results owed", n_cycles, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls set at the falling edge, ~26 in a hundred.
  always @(negedge clk_i) begin
    if (rst_ni)
      out_stall_i <= !quiet && ($urandom_range(99) < 26);
  end

  // Result beats are taken at the rising edge, before any flop updates.
  always @(posedge clk_i) begin
    quat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.w = quat_w_o;
      got.x = quat_x_o;
      got.y = quat_y_o;
      got.z = quat_z_o;
      sb.check_quat(got);
    end
  end

  // One input beat: optional idle cycles, then hold valid until accepted.
  // Valid stays high into the next beat, so it is never dropped and raised
  // in the same step.
  task automatic send_vector(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] vz);
    while (!quiet && ($urandom_range(99) < 26)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_x_i    <= vx;
    vec_y_i    <= vy;
    vec_z_i    <= vz;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vector(vx, vy, vz);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_component();
    int k;
    k = $urandom_range(99);
    if (k < 55) return 16'($urandom);
    if (k < 85) return 16'($signed($urandom_range(1024)) - 512);
    case ($urandom_range(4))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sh4000;
      3: return -16'sh4000;
      default: return 16'sh0000;
    endcase
  endfunction

  initial begin
    logic signed [15:0] dir_vec[N_DIRECTED][3];
    sb          = new();
    n_cycles    = 0;
    n_sent      = 0;
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    vec_x_i     = '0;
    vec_y_i     = '0;
    vec_z_i     = '0;

    // directed: null rotation, single axes at the extremes, mixed signs,
    // small steps, and large steps that drive components into saturation
    dir_vec = '{
      '{16'sh0000, 16'sh0000, 16'sh0000},
      '{16'sh7FFF, 16'sh0000, 16'sh0000},
      '{16'sh0000, 16'sh7FFF, 16'sh0000},
      '{16'sh0000, 16'sh0000, 16'sh7FFF},
      '{-16'sh8000, 16'sh0000, 16'sh0000},
      '{16'sh0000, -16'sh8000, 16'sh0000},
      '{16'sh0000, 16'sh0000, -16'sh8000},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{-16'sh8000, -16'sh8000, -16'sh8000},
      '{16'sh7FFF, -16'sh8000, 16'sh7FFF},
      '{-16'sh8000, 16'sh7FFF, -16'sh8000},
      '{16'sh0001, 16'sh0000, 16'sh0000},
      '{-16'sh0001, -16'sh0001, -16'sh0001},
      '{16'sh0001, 16'sh0001, 16'sh0001},
      '{16'sh4000, 16'sh0000, 16'sh0000},
      '{16'sh0000, 16'sh4000, -16'sh4000},
      '{16'sh0100, -16'sh0200, 16'sh0300},
      '{16'sh5555, 16'sh2AAA, -16'sh5556},
      '{-16'sh2AAB, 16'sh5555, 16'sh2AAA},
      '{16'sh7FFF, 16'sh7FFF, -16'sh8000},
      '{16'sh0000, 16'sh0000, 16'sh0000},
      '{16'sh0010, -16'sh0010, 16'sh0008}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_vec[i])
      send_vector(dir_vec[i][0], dir_vec[i][1], dir_vec[i][2]);

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= QUIET_FIRST) && (i < QUIET_LAST);
      send_vector(pick_component(), pick_component(), pick_component());
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d rotation vectors (%0d directed), checked %0d quaternions",
             n_sent, N_DIRECTED, sb.n_checked);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
